/* hw/rtl/retry_bitmap_request_tracker_macros.svh */
// Assertion macros for the retry bitmap request tracker.
`ifndef RETRY_BITMAP_REQUEST_TRACKER_MACROS_SVH
`define RETRY_BITMAP_REQUEST_TRACKER_MACROS_SVH

// Condition holds at every edge outside reset.
`define RBRT_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Antecedent at one edge implies the consequent at the next.
`define RBRT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/rbrt_pkg.sv */
// Types and constants shared by the retry bitmap request tracker.
`timescale 1ns / 1ps
package rbrt_pkg;

   localparam int HEADER_BYTES = 7;
   localparam int IDX_W        = 18;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;

   localparam int POS_MAGIC_FIRST  = 0;
   localparam int POS_MAGIC_SECOND = 1;
   localparam int POS_TYPE         = 2;
   localparam int POS_TRANSFER_ID  = 3;
   localparam int POS_START_LOW    = 4;
   localparam int POS_START_HIGH   = 5;
   localparam int POS_LENGTH       = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAGIC_FIRST     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAGIC_SECOND    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RETRY_TYPE_CODE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRANSFER_ID     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOTAL_PACKETS   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRANSFER_ACTIVE = 3'd5;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_FETCH = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_ACCEPTED   = 3'd0,
      ST_INACTIVE   = 3'd1,
      ST_BAD_HEADER = 3'd2,
      ST_TRUNCATED  = 3'd3,
      ST_OVERFLOW   = 3'd4,
      ST_FETCH      = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_BIT,
      FSM_SEARCH,
      FSM_APPEND,
      FSM_FETCH,
      FSM_FINISH
   } fsm_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        resend_valid;
      logic [15:0] resend_index;
      logic [10:0] requested_count;
      logic [6:0]  pending_count;
      logic [31:0] retry_round;
   } rsp_type;

endpackage

/* hw/rtl/rbrt_ring_ram.sv */
// Single-port-write, registered-read memory holding the pending index ring.
`timescale 1ns / 1ps
module rbrt_ring_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/retry_bitmap_request_tracker.sv */
// Top level of the retry bitmap request tracker: packet parser, ring control and results.
`timescale 1ns / 1ps
`include "retry_bitmap_request_tracker_macros.svh"
// Takes retry-request control packets one byte per transfer (start while busy is low),
// plus fetch and clear commands, and keeps an ordered ring of packet indices to resend.
// Header bytes, trailing bytes and bytes past MAX_PACKET_BYTES are taken in the idle
// state. A bitmap byte steps through its eight bits; each in-range set bit is compared
// with the pending entries until a match or the end, and is appended if it is new. The
// duplicate search reads the pending memory one entry a cycle through its single read
// port. A final byte passes through the finish state and a fetch that pops through the
// fetch state; a clear or an empty fetch is answered from idle. Each result is shown on
// rsp_data for one cycle with rsp_valid high, the cycle after its command completes, and
// cannot be held off. The ring memory needs no clearing pass after reset.
module retry_bitmap_request_tracker
   import rbrt_pkg::*;
#(
   parameter int PENDING_DEPTH    = 64,
   parameter int MAX_PACKET_BYTES = 262
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(PENDING_DEPTH);
   localparam int CW = $clog2(PENDING_DEPTH + 1);
   localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
   localparam int LW = (PW > 9) ? PW : 9;

   logic [7:0]  magic_first_ff, magic_second_ff, type_code_ff, transfer_id_ff;
   logic [15:0] total_packets_ff;
   logic        active_ff;

   fsm_type     state_ff, state_in;
   logic [AW-1:0] rd_slot_ff, rd_slot_in;
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] app_ff, app_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [15:0] start_ff, start_in;
   logic [7:0]  len_ff, len_in;
   logic        hb_ff, hb_in;
   logic [10:0] reqrun_ff, reqrun_in;
   logic [31:0] round_ff, round_in;
   logic        err_ff, err_in;
   logic [7:0]  byte_ff, byte_in;
   logic [IDX_W-1:0] base_ff, base_in;
   logic [2:0]  bit_ff, bit_in;
   logic        last_ff, last_in;
   logic [AW-1:0] cmp_ff, cmp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [15:0] wr_data, rd_data;

   logic [IDX_W-1:0] cand_idx;
   logic        body;
   logic        complete;
   logic [CW-1:0] total_less;
   fsm_type     after_bits;

   function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
      logic [CW:0] sum;
      sum = (CW+1)'(a) + (CW+1)'(b);
      if (sum >= (CW+1)'(PENDING_DEPTH)) begin
         sum = sum - (CW+1)'(PENDING_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   rbrt_ring_ram #(
      .DEPTH (PENDING_DEPTH),
      .WIDTH (16)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cand_idx   = base_ff + IDX_W'(bit_ff);
   assign after_bits = last_ff ? FSM_FINISH : FSM_IDLE;
   assign total_less = total_ff - CW'(1);
   assign busy       = (state_ff != FSM_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      rd_slot_in   = rd_slot_ff;
      total_in     = total_ff;
      app_in       = app_ff;
      pos_in       = pos_ff;
      start_in     = start_ff;
      len_in       = len_ff;
      hb_in        = hb_ff;
      reqrun_in    = reqrun_ff;
      round_in     = round_ff;
      err_in       = err_ff;
      byte_in      = byte_ff;
      base_in      = base_ff;
      bit_in       = bit_ff;
      last_in      = last_ff;
      cmp_in       = cmp_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      wr_en        = 1'b0;
      wr_addr      = ring_add(rd_slot_ff, total_ff);
      wr_data      = cand_idx[15:0];
      rd_en        = 1'b0;
      rd_addr      = rd_slot_ff;
      body         = 1'b0;
      complete     = 1'b0;

      unique case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               if (req_data.kind == KIND_FETCH) begin
                  if (total_ff != '0) begin
                     rd_en    = 1'b1;
                     state_in = FSM_FETCH;
                  end else begin
                     rsp_valid_in               = 1'b1;
                     rsp_in.status              = ST_FETCH;
                     rsp_in.pending_count       = 7'(total_ff);
                     rsp_in.retry_round         = round_ff;
                  end
               end else if (req_data.kind == KIND_CLEAR) begin
                  rd_slot_in           = '0;
                  total_in             = '0;
                  app_in               = '0;
                  err_in               = 1'b0;
                  pos_in               = '0;
                  hb_in                = 1'b0;
                  reqrun_in            = '0;
                  rsp_valid_in         = 1'b1;
                  rsp_in.status        = ST_ACCEPTED;
                  rsp_in.retry_round   = round_ff;
               end else if (req_data.kind == KIND_BYTE) begin
                  if (pos_ff == '0) begin
                     hb_in     = err_ff;
                     reqrun_in = '0;
                     start_in  = '0;
                     len_in    = '0;
                     app_in    = '0;
                  end
                  state_in = req_data.last_byte ? FSM_FINISH : FSM_IDLE;
                  last_in  = req_data.last_byte;
                  if (LW'(pos_ff) < LW'(MAX_PACKET_BYTES)) begin
                     body = LW'(pos_ff) < LW'(HEADER_BYTES) + LW'(len_in);
                     if (body && !active_ff) begin
                        hb_in = 1'b1;
                     end
                     priority if (pos_ff == PW'(POS_MAGIC_FIRST)) begin
                        if (req_data.data_byte != magic_first_ff) hb_in = 1'b1;
                     end else if (pos_ff == PW'(POS_MAGIC_SECOND)) begin
                        if (req_data.data_byte != magic_second_ff) hb_in = 1'b1;
                     end else if (pos_ff == PW'(POS_TYPE)) begin
                        if (req_data.data_byte != type_code_ff) hb_in = 1'b1;
                     end else if (pos_ff == PW'(POS_TRANSFER_ID)) begin
                        if (req_data.data_byte != transfer_id_ff) hb_in = 1'b1;
                     end else if (pos_ff == PW'(POS_START_LOW)) begin
                        start_in = {8'd0, req_data.data_byte};
                     end else if (pos_ff == PW'(POS_START_HIGH)) begin
                        start_in = {req_data.data_byte, start_in[7:0]};
                     end else if (pos_ff == PW'(POS_LENGTH)) begin
                        len_in = req_data.data_byte;
                     end else begin
                        if (body && !hb_in && !err_ff) begin
                           byte_in  = req_data.data_byte;
                           bit_in   = '0;
                           base_in  = IDX_W'(start_in)
                                    + ((IDX_W'(pos_ff) - IDX_W'(HEADER_BYTES)) << 3);
                           state_in = FSM_BIT;
                        end
                     end
                     if (!hb_in && LW'(pos_ff) >= LW'(POS_LENGTH)
                         && LW'(pos_ff) + LW'(1) == LW'(HEADER_BYTES) + LW'(len_in)) begin
                        round_in = round_ff + 32'd1;
                     end
                     pos_in = pos_ff + PW'(1);
                  end
               end
            end
         end

         FSM_BIT: begin
            if (byte_ff[bit_ff] && cand_idx < IDX_W'(total_packets_ff)) begin
               reqrun_in = reqrun_ff + 11'd1;
               if (total_ff == '0) begin
                  state_in = FSM_APPEND;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = rd_slot_ff;
                  cmp_in   = '0;
                  state_in = FSM_SEARCH;
               end
            end else if (bit_ff == 3'd7) begin
               state_in = after_bits;
            end else begin
               bit_in = bit_ff + 3'd1;
            end
         end

         FSM_SEARCH: begin
            if (rd_data == cand_idx[15:0]) begin
               if (bit_ff == 3'd7) begin
                  state_in = after_bits;
               end else begin
                  bit_in   = bit_ff + 3'd1;
                  state_in = FSM_BIT;
               end
            end else if (CW'(cmp_ff) + CW'(1) == total_ff) begin
               state_in = FSM_APPEND;
            end else begin
               cmp_in  = cmp_ff + AW'(1);
               rd_en   = 1'b1;
               rd_addr = ring_add(rd_slot_ff, CW'(cmp_ff) + CW'(1));
            end
         end

         FSM_APPEND: begin
            if (total_ff == CW'(PENDING_DEPTH)) begin
               err_in     = 1'b1;
               rd_slot_in = '0;
               total_in   = '0;
               app_in     = '0;
               state_in   = after_bits;
            end else begin
               wr_en    = 1'b1;
               total_in = total_ff + CW'(1);
               app_in   = app_ff + CW'(1);
               if (bit_ff == 3'd7) begin
                  state_in = after_bits;
               end else begin
                  bit_in   = bit_ff + 3'd1;
                  state_in = FSM_BIT;
               end
            end
         end

         FSM_FETCH: begin
            rd_slot_in = (CW'(rd_slot_ff) + CW'(1) == CW'(PENDING_DEPTH))
                       ? '0 : rd_slot_ff + AW'(1);
            total_in   = total_less;
            app_in     = (app_ff > total_less) ? total_less : app_ff;
            rsp_valid_in         = 1'b1;
            rsp_in.status        = ST_FETCH;
            rsp_in.resend_valid  = 1'b1;
            rsp_in.resend_index  = rd_data;
            rsp_in.pending_count = 7'(total_less);
            rsp_in.retry_round   = round_ff;
            state_in             = FSM_IDLE;
         end

         FSM_FINISH: begin
            pos_in   = '0;
            complete = LW'(pos_ff) >= LW'(HEADER_BYTES)
                     && LW'(pos_ff) >= LW'(HEADER_BYTES) + LW'(len_ff);
            rsp_valid_in       = 1'b1;
            rsp_in.retry_round = round_ff;
            if (err_ff) begin
               rsp_in.status = ST_OVERFLOW;
            end else if (complete && !hb_ff) begin
               app_in                 = '0;
               rsp_in.status          = ST_ACCEPTED;
               rsp_in.requested_count = reqrun_ff;
            end else begin
               total_in = (app_ff <= total_ff) ? total_ff - app_ff : '0;
               app_in   = '0;
               if (!active_ff) begin
                  rsp_in.status = ST_INACTIVE;
               end else if (hb_ff || LW'(pos_ff) < LW'(HEADER_BYTES)) begin
                  rsp_in.status = ST_BAD_HEADER;
               end else begin
                  rsp_in.status = ST_TRUNCATED;
               end
            end
            rsp_in.pending_count = 7'(total_in);
            state_in             = FSM_IDLE;
         end

         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= FSM_IDLE;
         rd_slot_ff       <= '0;
         total_ff         <= '0;
         app_ff           <= '0;
         pos_ff           <= '0;
         hb_ff            <= 1'b0;
         reqrun_ff        <= '0;
         round_ff         <= '0;
         err_ff           <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         magic_first_ff   <= '0;
         magic_second_ff  <= '0;
         type_code_ff     <= '0;
         transfer_id_ff   <= '0;
         total_packets_ff <= '0;
         active_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_slot_ff   <= rd_slot_in;
         total_ff     <= total_in;
         app_ff       <= app_in;
         pos_ff       <= pos_in;
         hb_ff        <= hb_in;
         reqrun_ff    <= reqrun_in;
         round_ff     <= round_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_MAGIC_FIRST:     magic_first_ff   <= csr_wdata[7:0];
               CSR_MAGIC_SECOND:    magic_second_ff  <= csr_wdata[7:0];
               CSR_RETRY_TYPE_CODE: type_code_ff     <= csr_wdata[7:0];
               CSR_TRANSFER_ID:     transfer_id_ff   <= csr_wdata[7:0];
               CSR_TOTAL_PACKETS:   total_packets_ff <= csr_wdata;
               CSR_TRANSFER_ACTIVE: active_ff        <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      len_ff   <= len_in;
      byte_ff  <= byte_in;
      base_ff  <= base_in;
      bit_ff   <= bit_in;
      last_ff  <= last_in;
      cmp_ff   <= cmp_in;
      rsp_ff   <= rsp_in;
   end

   `RBRT_ASSERT_ALWAYS(a_total_bound, total_ff <= CW'(PENDING_DEPTH), "ring occupancy past depth")
   `RBRT_ASSERT_ALWAYS(a_append_bound, app_ff <= total_ff, "tentative appends exceed occupancy")
   `RBRT_ASSERT_ALWAYS(a_error_empty, !err_ff || total_ff == '0, "ring not empty under error")
   `RBRT_ASSERT_ALWAYS(a_rsp_idle, !rsp_valid_ff || state_ff == FSM_IDLE, "result while busy")
   `RBRT_ASSERT_NEXT(a_fetch_pop, start && !busy && req_data.kind == KIND_FETCH && total_ff != '0, state_ff == FSM_FETCH, "pop not started")

endmodule

/* test/testbench.sv */
// Self-checking testbench for the retry bitmap request tracker: driver, monitor and predictor.
`timescale 1ns / 1ps
module testbench;
   import rbrt_pkg::*;

   localparam int          PEND_DEPTH    = 64;
   localparam int          MAX_BYTES     = 262;
   localparam int          SETTLE_CYCLES = 700;
   localparam int unsigned CYCLE_LIMIT   = 2500000;
   localparam logic [1:0]  KIND_UNUSED   = 2'd3;

   typedef struct {
      req_type cmd;
      bit      drain;
   } staged_cmd_t;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   start     = 1'b0;
   logic                   busy;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   rsp_type                rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   staged_cmd_t command_queue [$];
   rsp_type     awaited_replies [$];
   int unsigned replies_owed    = 0;
   int unsigned replies_checked = 0;
   int unsigned queued_count    = 0;
   int unsigned cycle_count     = 0;
   int unsigned fail_count      = 0;
   int          gap_left        = 0;
   int          calm_left       = 0;

   // tracker mirror: configuration
   logic [7:0]  cfg_magic0 = '0;
   logic [7:0]  cfg_magic1 = '0;
   logic [7:0]  cfg_type   = '0;
   logic [7:0]  cfg_tid    = '0;
   logic [15:0] cfg_total  = '0;
   bit          cfg_active = 1'b0;

   // tracker mirror: ring and packet parser
   logic [15:0] ring_mem [PEND_DEPTH];
   int unsigned ring_head = 0;
   int unsigned ring_fill = 0;
   int unsigned pkt_pos   = 0;
   int unsigned pkt_start = 0;
   int unsigned pkt_len   = 0;
   int unsigned pkt_adds  = 0;
   logic [10:0] tally     = '0;
   logic [31:0] round_cnt = '0;
   bit          pkt_bad   = 1'b0;
   bit          err_flag  = 1'b0;

   retry_bitmap_request_tracker #(
      .PENDING_DEPTH(PEND_DEPTH),
      .MAX_PACKET_BYTES(MAX_BYTES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void expect_reply(status_type st, bit vld, logic [15:0] idx,
                                        logic [10:0] req);
      rsp_type r;
      r.status          = st;
      r.resend_valid    = vld;
      r.resend_index    = idx;
      r.requested_count = req;
      r.pending_count   = ring_fill[6:0];
      r.retry_round     = round_cnt;
      awaited_replies.push_back(r);
      replies_owed++;
   endfunction

   function automatic void scan_bits(int unsigned byte_ofs, logic [7:0] bits);
      int unsigned pkt_idx;
      bit dup;
      for (int b = 0; b < 8; b++) begin
         if (err_flag) return;
         if (bits[b]) begin
            pkt_idx = pkt_start + byte_ofs * 8 + b;
            if (pkt_idx < cfg_total) begin
               tally = tally + 11'd1;
               dup = 1'b0;
               for (int k = 0; k < ring_fill; k++)
                  if (ring_mem[(ring_head + k) % PEND_DEPTH] == pkt_idx[15:0]) dup = 1'b1;
               if (!dup) begin
                  if (ring_fill >= PEND_DEPTH) begin
                     err_flag  = 1'b1;
                     ring_head = 0;
                     ring_fill = 0;
                     pkt_adds  = 0;
                     return;
                  end
                  ring_mem[(ring_head + ring_fill) % PEND_DEPTH] = pkt_idx[15:0];
                  ring_fill++;
                  pkt_adds++;
               end
            end
         end
      end
   endfunction

   function automatic void advance_tracker(req_type it);
      int unsigned fin;
      bit body;
      bit whole;
      status_type st;
      logic [15:0] popped;
      case (it.kind)
         KIND_FETCH: begin
            if (ring_fill > 0) begin
               popped    = ring_mem[ring_head];
               ring_head = (ring_head + 1) % PEND_DEPTH;
               ring_fill--;
               if (pkt_adds > ring_fill) pkt_adds = ring_fill;
               expect_reply(ST_FETCH, 1'b1, popped, '0);
            end else begin
               expect_reply(ST_FETCH, 1'b0, '0, '0);
            end
         end
         KIND_CLEAR: begin
            ring_head = 0;
            ring_fill = 0;
            pkt_adds  = 0;
            err_flag  = 1'b0;
            pkt_pos   = 0;
            pkt_bad   = 1'b0;
            tally     = '0;
            expect_reply(ST_ACCEPTED, 1'b0, '0, '0);
         end
         KIND_BYTE: begin
            if (pkt_pos == 0) begin
               pkt_bad   = err_flag;
               tally     = '0;
               pkt_start = 0;
               pkt_len   = 0;
               pkt_adds  = 0;
            end
            if (pkt_pos < MAX_BYTES) begin
               body = pkt_pos < HEADER_BYTES + pkt_len;
               if (body && !cfg_active) pkt_bad = 1'b1;
               case (pkt_pos)
                  POS_MAGIC_FIRST:  if (it.data_byte != cfg_magic0) pkt_bad = 1'b1;
                  POS_MAGIC_SECOND: if (it.data_byte != cfg_magic1) pkt_bad = 1'b1;
                  POS_TYPE:         if (it.data_byte != cfg_type) pkt_bad = 1'b1;
                  POS_TRANSFER_ID:  if (it.data_byte != cfg_tid) pkt_bad = 1'b1;
                  POS_START_LOW:    pkt_start = it.data_byte;
                  POS_START_HIGH:   pkt_start = pkt_start | (int'(it.data_byte) << 8);
                  POS_LENGTH:       pkt_len = it.data_byte;
                  default: begin
                     if (body && !pkt_bad && !err_flag)
                        scan_bits(pkt_pos - HEADER_BYTES, it.data_byte);
                  end
               endcase
               if (!pkt_bad && pkt_pos >= HEADER_BYTES - 1 &&
                   pkt_pos + 1 == HEADER_BYTES + pkt_len)
                  round_cnt = round_cnt + 32'd1;
               pkt_pos++;
            end
            if (it.last_byte) begin
               fin     = pkt_pos;
               pkt_pos = 0;
               whole   = fin >= HEADER_BYTES && fin >= HEADER_BYTES + pkt_len;
               if (err_flag) begin
                  expect_reply(ST_OVERFLOW, 1'b0, '0, '0);
               end else if (whole && !pkt_bad) begin
                  pkt_adds = 0;
                  expect_reply(ST_ACCEPTED, 1'b0, '0, tally);
               end else begin
                  // roll back this packet's appends
                  ring_fill = ring_fill - ((pkt_adds <= ring_fill) ? pkt_adds : ring_fill);
                  pkt_adds  = 0;
                  if (!cfg_active) st = ST_INACTIVE;
                  else if (pkt_bad || fin < HEADER_BYTES) st = ST_BAD_HEADER;
                  else st = ST_TRUNCATED;
                  expect_reply(st, 1'b0, '0, '0);
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic int pick_gap();
      int roll;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 45) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // driver: one transfer per start while busy is low
   always @(posedge clock) begin
      bit taken;
      if (reset) begin
         start    <= 1'b0;
         gap_left <= 0;
      end else begin
         taken = start && !busy;
         if (taken) advance_tracker(req_data);
         if (start && !taken) begin
            // hold the current item
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
         end else if (command_queue.size() > 0 &&
                      !(command_queue[0].drain && replies_checked != replies_owed)) begin
            req_data <= command_queue[0].cmd;
            start    <= 1'b1;
            gap_left <= pick_gap();
            void'(command_queue.pop_front());
         end else begin
            start <= 1'b0;
         end
      end
   end

   function automatic void compare_field(string label, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", label, want, got);
         fail_count++;
      end
   endfunction

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (awaited_replies.size() == 0) begin
            $error("unexpected reply: status %0d", rsp_data.status);
            fail_count++;
         end else begin
            want = awaited_replies.pop_front();
            compare_field("status", want.status, rsp_data.status);
            compare_field("resend_valid", want.resend_valid, rsp_data.resend_valid);
            compare_field("resend_index", want.resend_index, rsp_data.resend_index);
            compare_field("requested_count", want.requested_count, rsp_data.requested_count);
            compare_field("pending_count", want.pending_count, rsp_data.pending_count);
            compare_field("retry_round", want.retry_round, rsp_data.retry_round);
            replies_checked <= replies_checked + 1;
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         cycle_count <= cycle_count + 1;
      end
   end

   task automatic queue_cmd(logic [1:0] k, logic [7:0] d, bit last, bit drain);
      staged_cmd_t s;
      s.cmd.kind      = k;
      s.cmd.data_byte = d;
      s.cmd.last_byte = last;
      s.drain         = drain;
      command_queue.push_back(s);
      if (k != KIND_UNUSED) queued_count++;
   endtask

   task automatic queue_bytes(logic [7:0] pkt [$], bit close, bit mix_fetch);
      for (int j = 0; j < pkt.size(); j++) begin
         if (mix_fetch && j > 0 && $urandom_range(0, 99) < 3)
            queue_cmd(KIND_FETCH, 8'($urandom), 1'($urandom), 1'b0);
         queue_cmd(KIND_BYTE, pkt[j], close && (j == pkt.size() - 1), 1'b0);
      end
   endtask

   function automatic logic [7:0] bitmap_byte(int unsigned fill_pct);
      logic [7:0] v;
      for (int b = 0; b < 8; b++) v[b] = $urandom_range(0, 99) < fill_pct;
      return v;
   endfunction

   task automatic queue_request(logic [15:0] first_idx, int unsigned len, int unsigned fill_pct,
                                int unsigned bad_pos, int unsigned stop_len, bit close);
      logic [7:0] pkt [$];
      pkt.push_back(cfg_magic0);
      pkt.push_back(cfg_magic1);
      pkt.push_back(cfg_type);
      pkt.push_back(cfg_tid);
      pkt.push_back(first_idx[7:0]);
      pkt.push_back(first_idx[15:8]);
      pkt.push_back(8'(len));
      for (int j = 0; j < len; j++) pkt.push_back(bitmap_byte(fill_pct));
      while (pkt.size() < stop_len) pkt.push_back(8'($urandom));
      if (bad_pos < 4) pkt[bad_pos] = pkt[bad_pos] ^ 8'($urandom_range(1, 255));
      while (pkt.size() > stop_len) void'(pkt.pop_back());
      queue_bytes(pkt, close, 1'b1);
   endtask

   task automatic queue_traffic(int unsigned quota, int unsigned fill_pct, int unsigned long_pct);
      int unsigned goal;
      int unsigned roll;
      int unsigned len;
      int unsigned pick;
      logic [15:0] first_idx;
      goal = queued_count + quota;
      while (queued_count < goal) begin
         roll = $urandom_range(0, 99);
         len  = ($urandom_range(0, 99) < long_pct) ? $urandom_range(4, 12) : $urandom_range(0, 3);
         pick = $urandom_range(0, 9);
         if (pick == 0) first_idx = 16'hFFFF - 16'($urandom_range(0, 15));
         else if (pick == 1) first_idx = 16'($urandom);
         else first_idx = 16'($urandom_range(0, cfg_total));
         if (roll < 55) begin
            queue_request(first_idx, len, fill_pct, 4,
                          7 + len + (($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0),
                          1'b1);
         end else if (roll < 64) begin
            queue_request(first_idx, len, fill_pct, $urandom_range(0, 3), 7 + len, 1'b1);
         end else if (roll < 72) begin
            if (len == 0) len = 2;
            queue_request(first_idx, len, fill_pct, 4, $urandom_range(7, 6 + len), 1'b1);
         end else if (roll < 76) begin
            queue_request(first_idx, len, fill_pct, 4, $urandom_range(1, 6), 1'b1);
         end else if (roll < 90) begin
            repeat ($urandom_range(1, 3))
               queue_cmd(KIND_FETCH, 8'($urandom), 1'($urandom), $urandom_range(0, 19) == 0);
         end else if (roll < 95) begin
            if ($urandom_range(0, 1))
               queue_request(first_idx, len, fill_pct, 4, $urandom_range(1, 7 + len), 1'b0);
            queue_cmd(KIND_CLEAR, 8'($urandom), 1'($urandom), 1'b0);
         end else if (roll < 97) begin
            queue_cmd(KIND_UNUSED, 8'($urandom), 1'($urandom), 1'b0);
         end else begin
            repeat ($urandom_range(1, 4))
               queue_cmd(KIND_BYTE, 8'($urandom), 1'($urandom), 1'b0);
         end
      end
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_MAGIC_FIRST:     cfg_magic0 = val[7:0];
         CSR_MAGIC_SECOND:    cfg_magic1 = val[7:0];
         CSR_RETRY_TYPE_CODE: cfg_type   = val[7:0];
         CSR_TRANSFER_ID:     cfg_tid    = val[7:0];
         CSR_TOTAL_PACKETS:   cfg_total  = val[15:0];
         CSR_TRANSFER_ACTIVE: cfg_active = val[0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic [7:0] m0, logic [7:0] m1, logic [7:0] ty, logic [7:0] tid,
                             logic [15:0] total, bit active);
      write_reg(CSR_MAGIC_FIRST, {8'($urandom), m0});
      write_reg(CSR_MAGIC_SECOND, {8'($urandom), m1});
      write_reg(CSR_RETRY_TYPE_CODE, {8'($urandom), ty});
      write_reg(CSR_TRANSFER_ID, {8'($urandom), tid});
      write_reg(CSR_TOTAL_PACKETS, total);
      write_reg(CSR_TRANSFER_ACTIVE, {15'($urandom), active});
      @(negedge clock);
   endtask

   // wait for every transfer and reply, then let the last byte finish its scan
   task automatic settle();
      do @(negedge clock);
      while (command_queue.size() != 0 || start || replies_checked != replies_owed);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [7:0] seq [$];
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: inactive transfer
      queue_cmd(KIND_FETCH, 8'h00, 1'b0, 1'b0);
      seq = '{8'h00, 8'hFF};
      queue_bytes(seq, 1'b1, 1'b0);
      queue_cmd(KIND_UNUSED, 8'h5A, 1'b1, 1'b0);
      queue_cmd(KIND_CLEAR, 8'h00, 1'b0, 1'b0);
      settle();

      set_config(8'hA5, 8'h5A, 8'h03, 8'h11, 16'd200, 1'b1);
      // truncated after nine appends, then a full request with trailing byte
      seq = '{8'hA5, 8'h5A, 8'h03, 8'h11, 8'h00, 8'h00, 8'h03, 8'hFF, 8'h01};
      queue_bytes(seq, 1'b1, 1'b0);
      seq = '{8'hA5, 8'h5A, 8'h03, 8'h11, 8'hC0, 8'h00, 8'h02, 8'hFF, 8'hFF, 8'h00};
      queue_bytes(seq, 1'b1, 1'b0);
      queue_cmd(KIND_FETCH, 8'hFF, 1'b1, 1'b1);
      queue_traffic(110, 30, 10);
      settle();

      set_config(8'hFF, 8'h00, 8'hFF, 8'h00, 16'hFFFF, 1'b1);
      queue_traffic(110, 40, 10);
      settle();

      set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 16'd0, 1'b1);
      queue_traffic(60, 50, 10);
      settle();

      set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 16'd300, 1'b0);
      queue_traffic(60, 50, 10);
      settle();

      set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 16'd100, 1'b1);
      queue_traffic(120, 90, 30);
      settle();

      set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 16'($urandom_range(1, 400)), 1'b1);
      queue_cmd(KIND_CLEAR, 8'h00, 1'b0, 1'b0);
      // run past the maximum packet length
      queue_request(16'h0000, 255, 2, 4, MAX_BYTES + 6, 1'b1);
      queue_traffic(80, 30, 10);
      settle();

      if (awaited_replies.size() != 0) begin
         $error("%0d replies never arrived", awaited_replies.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
